>>> rtl/whsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header stream parser package
// Parse phases, status and kind codes, and the types shared by the modules.
// ----------------------------------------------------------------------------
package whsp_pkg;

	localparam logic [3:0] PH_RIFF     = 4'd0;
	localparam logic [3:0] PH_FSIZE    = 4'd1;
	localparam logic [3:0] PH_WAVE     = 4'd2;
	localparam logic [3:0] PH_FMT      = 4'd3;
	localparam logic [3:0] PH_FMTSIZE  = 4'd4;
	localparam logic [3:0] PH_FMTBODY  = 4'd5;
	localparam logic [3:0] PH_CHUNKHDR = 4'd6;
	localparam logic [3:0] PH_SKIP     = 4'd7;
	localparam logic [3:0] PH_DATA     = 4'd8;
	localparam logic [3:0] PH_DONE     = 4'd9;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_RIFF    = 4'd1;
	localparam logic [3:0] ST_FSIZE   = 4'd2;
	localparam logic [3:0] ST_WAVE    = 4'd3;
	localparam logic [3:0] ST_FMT     = 4'd4;
	localparam logic [3:0] ST_FMTSIZE = 4'd5;
	localparam logic [3:0] ST_FMTBODY = 4'd6;
	localparam logic [3:0] ST_TAG     = 4'd7;
	localparam logic [3:0] ST_CHAN    = 4'd8;
	localparam logic [3:0] ST_RATE    = 4'd9;
	localparam logic [3:0] ST_ALIGN   = 4'd10;
	localparam logic [3:0] ST_BITS    = 4'd11;
	localparam logic [3:0] ST_CHSIZE  = 4'd12;
	localparam logic [3:0] ST_DATA    = 4'd13;
	localparam logic [3:0] ST_UNSUP   = 4'd14;
	localparam logic [3:0] ST_NODATA  = 4'd15;

	localparam logic [1:0] TAG_PCM   = 2'd0;
	localparam logic [1:0] TAG_FLOAT = 2'd1;
	localparam logic [1:0] TAG_OGG   = 2'd2;
	localparam logic [1:0] TAG_BAD   = 2'd3;

	localparam logic [15:0] RAW_PCM   = 16'h0001;
	localparam logic [15:0] RAW_FLOAT = 16'h0003;
	localparam logic [15:0] RAW_OGG   = 16'h4F67;

	localparam logic [2:0] KIND_I8  = 3'd0;
	localparam logic [2:0] KIND_I16 = 3'd1;
	localparam logic [2:0] KIND_I32 = 3'd2;
	localparam logic [2:0] KIND_I64 = 3'd3;
	localparam logic [2:0] KIND_F32 = 3'd4;
	localparam logic [2:0] KIND_F64 = 3'd5;

	localparam logic [31:0] DATA_ID = 32'h61746164;

	typedef struct packed {
		logic step;
		logic show_pay;
		logic show_rep;
		logic div_start;
	} whsp_cmd_t;

	typedef struct packed {
		logic emit_pay;
		logic emit_rep;
		logic need_div;
	} whsp_stat_t;

	function automatic logic [7:0] magic_byte(input logic [3:0] phase, input logic [1:0] k);
		logic [31:0] word;
		case (phase)
			PH_RIFF: word = 32'h46464952;
			PH_WAVE: word = 32'h45564157;
			default: word = 32'h20746D66;
		endcase
		return word[{k, 3'b000} +: 8];
	endfunction

endpackage

>>> rtl/whsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV parser stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface whsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, in_byte, end_of_file, input ready);
	modport sink (input valid, in_byte, end_of_file, output ready);
endinterface

interface whsp_out_if;
	logic        valid;
	logic        ready;
	logic        is_report;
	logic [7:0]  payload_byte;
	logic [3:0]  status;
	logic [1:0]  format_tag;
	logic [15:0] channels;
	logic [31:0] frame_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] sample_bits;
	logic [31:0] frame_total;
	logic [2:0]  sample_kind;

	modport source (output valid, is_report, payload_byte, status, format_tag, channels,
		frame_rate, byte_rate, block_align, sample_bits, frame_total, sample_kind,
		input ready);
	modport sink (input valid, is_report, payload_byte, status, format_tag, channels,
		frame_rate, byte_rate, block_align, sample_bits, frame_total, sample_kind,
		output ready);
endinterface

>>> rtl/whsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame count divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module whsp_div
	import whsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [31:0] quo_q;
	logic [16:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[31]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

>>> rtl/whsp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV parser datapath
// Per-byte parse state, header field capture and the result registers.
// ----------------------------------------------------------------------------
module whsp_dp
	import whsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  whsp_cmd_t   cmd,
	output whsp_stat_t  stat,
	input  logic [7:0]  in_byte,
	input  logic        end_of_file,
	input  logic [31:0] div_quo,
	output logic [31:0] div_num,
	output logic [15:0] div_den,
	output logic        is_report,
	output logic [7:0]  payload_byte,
	output logic [3:0]  status,
	output logic [1:0]  format_tag,
	output logic [15:0] channels,
	output logic [31:0] frame_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] sample_bits,
	output logic [31:0] frame_total,
	output logic [2:0]  sample_kind
);

	logic [3:0]  phase_q, n_phase;
	logic [31:0] fs_q, n_fs;
	logic [31:0] brem_q, n_brem;
	logic [4:0]  fseen_q, n_fseen;
	logic [1:0]  tag_q, n_tag;
	logic [15:0] ch_q, n_ch;
	logic [31:0] rate_q, n_rate;
	logic [31:0] brate_q, n_brate;
	logic [15:0] align_q, n_align;
	logic [15:0] bits_q, n_bits;
	logic [31:0] dlen_q, n_dlen;
	logic [2:0]  bcnt_q, n_bcnt;

	logic        rep, pay, fin;
	logic [3:0]  st, st_fin;
	logic [1:0]  k;
	logic [12:0] width;
	logic [2:0]  kind;
	logic [1:0]  wshift;
	logic        need_div;

	logic [7:0]  pay_q;
	logic [3:0]  r_status_q;
	logic [1:0]  r_tag_q;
	logic [15:0] r_ch_q;
	logic [31:0] r_rate_q;
	logic [31:0] r_brate_q;
	logic [15:0] r_align_q;
	logic [15:0] r_bits_q;
	logic [2:0]  r_kind_q;
	logic        r_div_q;
	logic [31:0] num_q;

	assign k = bcnt_q[1:0];

	always_comb begin
		logic [4:0]  i;
		logic [15:0] raw;
		n_phase = phase_q;
		n_fs    = fs_q;
		n_brem  = brem_q;
		n_fseen = fseen_q;
		n_tag   = tag_q;
		n_ch    = ch_q;
		n_rate  = rate_q;
		n_brate = brate_q;
		n_align = align_q;
		n_bits  = bits_q;
		n_dlen  = dlen_q;
		n_bcnt  = bcnt_q;
		rep     = 1'b0;
		pay     = 1'b0;
		fin     = 1'b0;
		st      = ST_OK;
		i       = fseen_q;
		raw     = '0;
		case (phase_q)
			PH_RIFF, PH_WAVE, PH_FMT: begin
				if (in_byte != magic_byte(phase_q, k)) begin
					rep = 1'b1;
					st  = (phase_q == PH_RIFF) ? ST_RIFF :
					      (phase_q == PH_WAVE) ? ST_WAVE : ST_FMT;
				end else if (k == 2'd3) begin
					n_phase = (phase_q == PH_RIFF) ? PH_FSIZE :
					          (phase_q == PH_WAVE) ? PH_FMT : PH_FMTSIZE;
					n_bcnt  = '0;
					n_fs    = '0;
				end else begin
					n_bcnt = {1'b0, k} + 3'd1;
				end
			end
			PH_FSIZE, PH_FMTSIZE: begin
				n_fs = {in_byte, fs_q[31:8]};
				if (k == 2'd3) begin
					n_bcnt = '0;
					if (phase_q == PH_FSIZE) begin
						n_phase = PH_WAVE;
					end else begin
						n_brem  = n_fs;
						n_fs    = '0;
						n_phase = PH_FMTBODY;
						fin     = (n_brem == '0);
					end
				end else begin
					n_bcnt = {1'b0, k} + 3'd1;
				end
			end
			PH_FMTBODY: begin
				if (i < 5'd16) begin
					if (i < 5'd2) begin
						n_fs = fs_q | ({24'd0, in_byte} << {i[0], 3'b000});
						if (i == 5'd1) begin
							raw   = n_fs[15:0];
							n_tag = (raw == RAW_PCM) ? TAG_PCM : (raw == RAW_FLOAT) ? TAG_FLOAT :
							        (raw == RAW_OGG) ? TAG_OGG : TAG_BAD;
						end
					end else if (i < 5'd4) begin
						n_ch = ch_q | ({8'd0, in_byte} << {i[0], 3'b000});
					end else if (i < 5'd8) begin
						n_rate = rate_q | ({24'd0, in_byte} << {i[1:0], 3'b000});
					end else if (i < 5'd12) begin
						n_brate = brate_q | ({24'd0, in_byte} << {i[1:0], 3'b000});
					end else if (i < 5'd14) begin
						n_align = align_q | ({8'd0, in_byte} << {i[0], 3'b000});
					end else begin
						n_bits = bits_q | ({8'd0, in_byte} << {i[0], 3'b000});
					end
					n_fseen = i + 5'd1;
				end
				n_brem = brem_q - 32'd1;
				fin    = (n_brem == '0);
			end
			PH_CHUNKHDR: begin
				if (bcnt_q < 3'd4) begin
					n_fs = {in_byte, fs_q[31:8]};
				end else begin
					n_dlen = {in_byte, dlen_q[31:8]};
				end
				if (bcnt_q == 3'd7) begin
					n_bcnt = '0;
					n_brem = n_dlen;
					if (n_fs == DATA_ID) begin
						if (n_dlen == '0) begin
							rep = 1'b1;
							st  = ST_OK;
						end else begin
							n_phase = PH_DATA;
						end
					end else if (n_dlen != '0) begin
						n_phase = PH_SKIP;
					end
				end else begin
					n_bcnt = bcnt_q + 3'd1;
				end
			end
			PH_SKIP: begin
				n_brem = brem_q - 32'd1;
				if (n_brem == '0) begin
					n_phase = PH_CHUNKHDR;
					n_bcnt  = '0;
				end
			end
			PH_DATA: begin
				pay    = 1'b1;
				n_brem = brem_q - 32'd1;
				if (n_brem == '0) begin
					rep = 1'b1;
					st  = ST_OK;
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			if (n_fseen < 5'd2 || n_tag == TAG_BAD) begin
				rep = 1'b1;
				st  = ST_TAG;
			end else if (n_fseen < 5'd4) begin
				rep = 1'b1;
				st  = ST_CHAN;
			end else if (n_fseen < 5'd12) begin
				rep = 1'b1;
				st  = ST_RATE;
			end else if (n_fseen < 5'd14) begin
				rep = 1'b1;
				st  = ST_ALIGN;
			end else if (n_fseen < 5'd16) begin
				rep = 1'b1;
				st  = ST_BITS;
			end else begin
				n_phase = PH_CHUNKHDR;
				n_bcnt  = '0;
			end
		end
		if (rep) begin
			n_phase = PH_DONE;
		end
		if (end_of_file && !rep && n_phase != PH_DONE) begin
			rep = 1'b1;
			case (n_phase)
				PH_RIFF:     st = ST_RIFF;
				PH_FSIZE:    st = ST_FSIZE;
				PH_WAVE:     st = ST_WAVE;
				PH_FMT:      st = ST_FMT;
				PH_FMTSIZE:  st = ST_FMTSIZE;
				PH_FMTBODY:  st = ST_FMTBODY;
				PH_CHUNKHDR: st = (n_bcnt < 3'd4) ? ST_NODATA : ST_CHSIZE;
				PH_DATA:     st = ST_DATA;
				default:     st = ST_NODATA;
			endcase
		end
	end

	always_comb begin
		width  = n_bits[15:3];
		st_fin = st;
		kind   = KIND_I8;
		wshift = 2'd0;
		case (width)
			13'd2:   wshift = 2'd1;
			13'd4:   wshift = 2'd2;
			13'd8:   wshift = 2'd3;
			default: wshift = 2'd0;
		endcase
		if (st == ST_OK) begin
			if (n_tag == TAG_PCM && (width == 13'd1 || width == 13'd2 ||
			                         width == 13'd4 || width == 13'd8)) begin
				kind = (width == 13'd1) ? KIND_I8 : (width == 13'd2) ? KIND_I16 :
				       (width == 13'd4) ? KIND_I32 : KIND_I64;
			end else if (n_tag == TAG_FLOAT && (width == 13'd4 || width == 13'd8)) begin
				kind = (width == 13'd4) ? KIND_F32 : KIND_F64;
			end else begin
				st_fin = ST_UNSUP;
			end
		end
		need_div = rep && st_fin == ST_OK && n_ch != '0;
	end

	assign stat.emit_pay = pay;
	assign stat.emit_rep = rep;
	assign stat.need_div = need_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			fs_q    <= '0;
			brem_q  <= '0;
			fseen_q <= '0;
			tag_q   <= TAG_PCM;
			ch_q    <= '0;
			rate_q  <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q  <= '0;
			dlen_q  <= '0;
			bcnt_q  <= '0;
		end else if (cmd.step) begin
			if (end_of_file) begin
				phase_q <= PH_RIFF;
				fs_q    <= '0;
				brem_q  <= '0;
				fseen_q <= '0;
				tag_q   <= TAG_PCM;
				ch_q    <= '0;
				rate_q  <= '0;
				brate_q <= '0;
				align_q <= '0;
				bits_q  <= '0;
				dlen_q  <= '0;
				bcnt_q  <= '0;
			end else begin
				phase_q <= n_phase;
				fs_q    <= n_fs;
				brem_q  <= n_brem;
				fseen_q <= n_fseen;
				tag_q   <= n_tag;
				ch_q    <= n_ch;
				rate_q  <= n_rate;
				brate_q <= n_brate;
				align_q <= n_align;
				bits_q  <= n_bits;
				dlen_q  <= n_dlen;
				bcnt_q  <= n_bcnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && pay) begin
			pay_q <= in_byte;
		end
		if (cmd.step && rep) begin
			r_status_q <= st_fin;
			r_tag_q    <= (n_tag == TAG_BAD) ? TAG_PCM : n_tag;
			r_ch_q     <= n_ch;
			r_rate_q   <= n_rate;
			r_brate_q  <= n_brate;
			r_align_q  <= n_align;
			r_bits_q   <= n_bits;
			r_kind_q   <= (st_fin == ST_OK) ? kind : KIND_I8;
			r_div_q    <= need_div;
			num_q      <= n_dlen >> wshift;
		end
	end

	assign div_num = num_q;
	assign div_den = r_ch_q;

	assign is_report    = cmd.show_rep;
	assign payload_byte = cmd.show_pay ? pay_q : 8'd0;
	assign status       = cmd.show_rep ? r_status_q : ST_OK;
	assign format_tag   = cmd.show_rep ? r_tag_q : TAG_PCM;
	assign channels     = cmd.show_rep ? r_ch_q : 16'd0;
	assign frame_rate   = cmd.show_rep ? r_rate_q : 32'd0;
	assign byte_rate    = cmd.show_rep ? r_brate_q : 32'd0;
	assign block_align  = cmd.show_rep ? r_align_q : 16'd0;
	assign sample_bits  = cmd.show_rep ? r_bits_q : 16'd0;
	assign frame_total  = (cmd.show_rep && r_div_q) ? div_quo : 32'd0;
	assign sample_kind  = cmd.show_rep ? r_kind_q : KIND_I8;

endmodule

>>> rtl/whsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV parser controller
// Sequences byte intake, payload transfer, frame count division and report.
// ----------------------------------------------------------------------------
module whsp_ctrl
	import whsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  whsp_stat_t stat,
	input  logic       div_done,
	output whsp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PAY    = 3'd1;
	localparam logic [2:0] S_DSTART = 3'd2;
	localparam logic [2:0] S_DWAIT  = 3'd3;
	localparam logic [2:0] S_REP    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       rep_q, div_q;
	logic       in_acc;

	assign in_ready  = state_q == S_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = state_q == S_PAY || state_q == S_REP;

	assign cmd.step      = in_acc;
	assign cmd.show_pay  = state_q == S_PAY;
	assign cmd.show_rep  = state_q == S_REP;
	assign cmd.div_start = state_q == S_DSTART;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (stat.emit_pay) begin
						state_d = S_PAY;
					end else if (stat.emit_rep) begin
						state_d = stat.need_div ? S_DSTART : S_REP;
					end
				end
			end
			S_PAY: begin
				if (out_ready) begin
					state_d = !rep_q ? S_IDLE : div_q ? S_DSTART : S_REP;
				end
			end
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_done) begin
					state_d = S_REP;
				end
			end
			S_REP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rep_q   <= 1'b0;
			div_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				rep_q <= stat.emit_rep;
				div_q <= stat.need_div;
			end
		end
	end

	a_no_result_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !stat.emit_pay && !stat.emit_rep |=> state_q == S_IDLE)
		else $error("byte without result did not return to idle");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside wait state");

	a_report_follows_payload: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAY && out_ready && rep_q |=> state_q == S_DSTART || state_q == S_REP)
		else $error("report lost after payload transfer");

	a_div_only_with_report: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && stat.need_div |-> stat.emit_rep)
		else $error("division requested without report");

endmodule

>>> rtl/wav_header_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header stream parser
// Checks a RIFF/WAVE header byte by byte, passes data-chunk bytes and reports.
// ----------------------------------------------------------------------------
// Usage:
//   wav    : byte input, in_byte with end_of_file on the final byte of a file.
//   result : payload transfers (is_report 0) for each data-chunk byte, then one
//            report transfer (is_report 1) with the header fields and status.
//   A byte is taken when the block is idle; a byte that yields no result leaves
//   the block ready again on the next cycle. A byte that yields a result holds
//   intake until its results are taken: payload appears in the cycle after the
//   byte, and an ok report with nonzero channels first waits on the bit-serial
//   frame count division (32 quotient bits plus load and finish). Payload bytes
//   go one at a time: the next byte is taken only once the payload is taken.
//   A stalled receiver holds the result and intake waits.
//   Reset returns the parser to expecting the RIFF magic with all held fields
//   cleared; end_of_file does the same after its byte.
// ----------------------------------------------------------------------------
module wav_header_stream_parser
	import whsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	whsp_in_if.sink           wav,
	whsp_out_if.source        result
);

	whsp_cmd_t   cmd;
	whsp_stat_t  stat;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] div_num;
	logic [15:0] div_den;

	whsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wav.valid),
		.in_ready  (wav.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.div_done  (div_done),
		.cmd       (cmd)
	);

	whsp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_byte      (wav.in_byte),
		.end_of_file  (wav.end_of_file),
		.div_quo      (div_quo),
		.div_num      (div_num),
		.div_den      (div_den),
		.is_report    (result.is_report),
		.payload_byte (result.payload_byte),
		.status       (result.status),
		.format_tag   (result.format_tag),
		.channels     (result.channels),
		.frame_rate   (result.frame_rate),
		.byte_rate    (result.byte_rate),
		.block_align  (result.block_align),
		.sample_bits  (result.sample_bits),
		.frame_total  (result.frame_total),
		.sample_kind  (result.sample_kind)
	);

	whsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

endmodule
